// ===== rtl/double_ended_queue_top_defines.svh =====
// Assertion macros shared by the deque checker.
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// Checked on every rising edge outside reset.
`define DQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define DQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dq_pkg.sv =====
// Package with the shared types and constants of the double-ended queue.
package dq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int OCC_W     = 5;
  localparam int MODE_W    = 2;
  localparam int STAT_W    = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_BACK  = 2'd0,
    MODE_PUSH_FRONT = 2'd1,
    MODE_POP_BACK   = 2'd2,
    MODE_POP_FRONT  = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_RESP
  } state_t;

endpackage

// ===== rtl/double_ended_queue_top.sv =====
// Top level of the bounded double-ended queue of signed 32-bit words.
//
// Usage:
// The input channel (in_valid, in_ready, in_mode, in_push_value) carries one
// request: push at the back, push at the front, pop at the back or pop at
// the front. The result channel (out_valid, out_ready, out_*) returns exactly
// one result per request: the front and back words after the operation (both
// all ones when the queue is empty), the occupancy and a status code.
// A push to a full queue or a pop from an empty one leaves the queue as it
// was and is flagged in the status.
// A request passes through an accept step that updates the front pointer and
// the count and writes a pushed word, a step that presents the new front and
// back addresses to the ring memory, and a capture step that moves the
// registered read data into the output register. The input side takes no new
// request until the capture step is done, so requests never overlap.
// The output register parts the two channels: a new request is taken while
// the previous result still waits. If the receiver stalls, the block holds
// in its capture cycle until the output register is free.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; the ring memory itself is not cleared and needs no clearing pass.
module double_ended_queue_top #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [dq_pkg::MODE_W-1:0]       in_mode,
  input  logic signed [dq_pkg::DATA_W-1:0] in_push_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [dq_pkg::DATA_W-1:0] out_front_value,
  output logic signed [dq_pkg::DATA_W-1:0] out_back_value,
  output logic [dq_pkg::OCC_W-1:0]        out_occupancy,
  output logic [dq_pkg::STAT_W-1:0]       out_status
);

  // Index width, count width (holds DEPTH itself) and a sum width for
  // pointer plus count before the modulo correction.
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  dq_pkg::state_t  state_r, state_nxt;
  logic [AW-1:0]   fp_r, fp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  dq_pkg::status_t st_r, st_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [dq_pkg::DATA_W-1:0] front_r, front_nxt;
  logic [dq_pkg::DATA_W-1:0] back_r, back_nxt;
  logic [dq_pkg::OCC_W-1:0]  occ_r, occ_nxt;
  dq_pkg::status_t           ost_r, ost_nxt;

  dq_pkg::mode_t             mode;
  logic                      accept;
  logic                      is_push;
  logic                      full;
  logic                      empty;
  logic [AW-1:0]             fp_dec;
  logic [AW-1:0]             fp_inc;
  logic [SW-1:0]             tail_sum;
  logic [AW-1:0]             tail_idx;
  logic [SW-1:0]             last_sum;
  logic [AW-1:0]             last_idx;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [dq_pkg::DATA_W-1:0] rd_front;
  logic [dq_pkg::DATA_W-1:0] rd_back;

  assign mode    = dq_pkg::mode_t'(in_mode);
  assign is_push = (mode == dq_pkg::MODE_PUSH_BACK) || (mode == dq_pkg::MODE_PUSH_FRONT);
  assign full    = (cnt_r >= DEPTH_C);
  assign empty   = (cnt_r == '0);

  // Ring arithmetic: every sum stays below twice the depth, so one compare
  // and subtract replaces the modulo.
  assign fp_dec   = (fp_r == '0) ? LAST_IDX : fp_r - 1'b1;
  assign fp_inc   = (fp_r == LAST_IDX) ? '0 : fp_r + 1'b1;
  assign tail_sum = SW'(fp_r) + SW'(cnt_r);
  assign tail_idx = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
  assign last_sum = tail_sum - 1'b1;
  assign last_idx = (last_sum >= DEPTH_S) ? AW'(last_sum - DEPTH_S) : AW'(last_sum);

  // A pushed word is written in the accept cycle and the end entries are
  // read in the cycle after it, so a read never meets a write to the same entry.
  assign ram_we    = accept && is_push && !full;
  assign ram_waddr = (mode == dq_pkg::MODE_PUSH_BACK) ? tail_idx : fp_dec;

  dq_ram #(
    .WIDTH (dq_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (in_push_value),
    .raddr_a (fp_r),
    .rdata_a (rd_front),
    .raddr_b (last_idx),
    .rdata_b (rd_back)
  );

  assign in_ready = (state_r == dq_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    fp_nxt        = fp_r;
    cnt_nxt       = cnt_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r;
    front_nxt     = front_r;
    back_nxt      = back_r;
    occ_nxt       = occ_r;
    ost_nxt       = ost_r;

    // The receiver takes the pending result.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      dq_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = dq_pkg::S_READ;
          st_nxt    = dq_pkg::ST_OK;
          if (is_push) begin
            if (full) begin
              st_nxt = dq_pkg::ST_FULL;
            end else begin
              cnt_nxt = cnt_r + 1'b1;
              if (mode == dq_pkg::MODE_PUSH_FRONT) begin
                fp_nxt = fp_dec;
              end
            end
          end else begin
            if (empty) begin
              st_nxt = dq_pkg::ST_EMPTY;
            end else begin
              cnt_nxt = cnt_r - 1'b1;
              if (mode == dq_pkg::MODE_POP_FRONT) begin
                fp_nxt = fp_inc;
              end
            end
          end
        end
      end
      dq_pkg::S_READ: begin
        state_nxt = dq_pkg::S_RESP;
      end
      dq_pkg::S_RESP: begin
        // Capture only once the output register is free or being emptied.
        if (!out_valid_r || out_ready) begin
          state_nxt     = dq_pkg::S_IDLE;
          out_valid_nxt = 1'b1;
          front_nxt     = empty ? '1 : rd_front;
          back_nxt      = empty ? '1 : rd_back;
          occ_nxt       = dq_pkg::OCC_W'(cnt_r);
          ost_nxt       = st_r;
        end
      end
      default: begin
        state_nxt = dq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dq_pkg::S_IDLE;
      fp_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fp_r        <= fp_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r    <= st_nxt;
    front_r <= front_nxt;
    back_r  <= back_nxt;
    occ_r   <= occ_nxt;
    ost_r   <= ost_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_front_value = front_r;
  assign out_back_value  = back_r;
  assign out_occupancy   = occ_r;
  assign out_status      = ost_r;

endmodule

// ===== rtl/dq_ram.sv =====
// Generic RAM with one write port and two registered read ports.
module dq_ram #(
  parameter int WIDTH = dq_pkg::DATA_W,
  parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ===== rtl/dq_checker.sv =====
// Port-level assertion checker for the double-ended queue, with its bind.
`include "double_ended_queue_top_defines.svh"

module dq_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [dq_pkg::DATA_W-1:0] out_front_value,
  input logic signed [dq_pkg::DATA_W-1:0] out_back_value,
  input logic [dq_pkg::OCC_W-1:0]         out_occupancy,
  input logic [dq_pkg::STAT_W-1:0]        out_status
);

  localparam int PW = 2 * dq_pkg::DATA_W + dq_pkg::OCC_W + dq_pkg::STAT_W;

  logic          out_stall;
  logic          in_take;
  logic [PW-1:0] out_payload;
  logic          empty_report;
  logic          empty_view;

  assign out_stall    = out_valid && !out_ready;
  assign in_take      = in_valid && in_ready;
  assign out_payload  = {out_front_value, out_back_value, out_occupancy, out_status};
  assign empty_report = out_valid && (out_status == dq_pkg::ST_EMPTY);
  assign empty_view   = (out_occupancy == '0) && (out_front_value == -1) &&
                        (out_back_value == -1);

  // A stalled result keeps its values.
  `DQ_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(out_payload), "stalled result changed")

  // Reset drops any pending result.
  `DQ_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_valid, "result pending after reset")

  // One request at a time: after an accept the input side closes.
  `DQ_ASSERT(a_one_inflight, in_take |=> !in_ready, "request accepted while busy")

  // A fresh result never appears without a request taken before it.
  `DQ_ASSERT(a_latency, $rose(out_valid) |-> $past(in_take, 3), "result without request")

  // A rejected pop reports an empty queue.
  `DQ_ASSERT(a_empty_pop, empty_report |-> empty_view, "bad empty-pop result")

endmodule

bind double_ended_queue_top dq_checker u_dq_checker (.*);

// ===== test/tb_double_ended_queue_top.sv =====
// Self-checking testbench for the bounded double-ended queue: a directed script, then random traffic.
module tb_double_ended_queue_top;

  localparam int DEPTH        = dq_pkg::DEPTH_DEF;
  localparam int SH_W         = $clog2(DEPTH);
  localparam int DATA_W       = dq_pkg::DATA_W;
  localparam int OCC_W        = dq_pkg::OCC_W;
  // This limit leaves ample room for the slowest correct run.
  localparam int CYCLE_LIMIT  = 200000;
  // This drain time after the last expected result is enough to catch a stray one.
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 463;

  localparam logic signed [DATA_W-1:0] EMPTY_WORD = -1;
  localparam logic signed [DATA_W-1:0] WORD_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] WORD_MIN   = 32'sh8000_0000;

  // This is what one result reports: both end words, the fill level and the status.
  typedef struct packed {
    logic signed [DATA_W-1:0] front_word;
    logic signed [DATA_W-1:0] back_word;
    logic [OCC_W-1:0]         fill;
    dq_pkg::status_t          stat;
  } deque_view_t;

  // This is one line of the directed script. A row with reps above one sends that many
  // requests, and the pushed word goes up by one each time. Where typed is set, the
  // expected view is the one written into the row. Otherwise the shadow queue below
  // supplies it.
  typedef struct packed {
    dq_pkg::mode_t            op;
    logic signed [DATA_W-1:0] word;
    int unsigned              reps;
    bit                       typed;
    deque_view_t              want;
  } script_row_t;

  logic                             clk;
  logic                             rst_n         = 1'b0;
  logic                             in_valid      = 1'b0;
  logic                             in_ready;
  logic [dq_pkg::MODE_W-1:0]        in_mode       = dq_pkg::MODE_PUSH_BACK;
  logic signed [DATA_W-1:0]         in_push_value = '0;
  logic                             out_valid;
  logic                             out_ready     = 1'b0;
  logic signed [DATA_W-1:0]         out_front_value;
  logic signed [DATA_W-1:0]         out_back_value;
  logic [OCC_W-1:0]                 out_occupancy;
  logic [dq_pkg::STAT_W-1:0]        out_status;

  // These are the shadow copy of the queue: a ring of words, the index of the front
  // entry and the number of entries held.
  logic signed [DATA_W-1:0] shadow_ring [DEPTH];
  int unsigned              shadow_front = 0;
  int unsigned              shadow_count = 0;

  deque_view_t              pending_views[$];
  script_row_t              script[$];
  int                       error_count        = 0;
  int                       cycle_count        = 0;
  int                       sender_idle_pct    = 0;
  int                       receiver_stall_pct = 0;

  double_ended_queue_top #(.DEPTH(DEPTH)) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_push_value  (in_push_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_front_value(out_front_value),
    .out_back_value (out_back_value),
    .out_occupancy  (out_occupancy),
    .out_status     (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The shadow queue applies one request and returns the view the block must report.
  // A push to a full queue and a pop from an empty one leave the queue unchanged. The
  // front index wraps modulo DEPTH in both directions.
  function automatic deque_view_t apply_deque_op(input dq_pkg::mode_t op,
                                                 input logic signed [DATA_W-1:0] word);
    deque_view_t view;
    view.stat = dq_pkg::ST_OK;
    if (op == dq_pkg::MODE_PUSH_BACK || op == dq_pkg::MODE_PUSH_FRONT) begin
      if (shadow_count == DEPTH) begin
        view.stat = dq_pkg::ST_FULL;
      end else if (op == dq_pkg::MODE_PUSH_BACK) begin
        shadow_ring[SH_W'((shadow_front + shadow_count) % DEPTH)] = word;
        shadow_count++;
      end else begin
        shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
        shadow_ring[SH_W'(shadow_front)] = word;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      view.stat = dq_pkg::ST_EMPTY;
    end else begin
      if (op == dq_pkg::MODE_POP_FRONT) begin
        shadow_front = (shadow_front + 1) % DEPTH;
      end
      shadow_count--;
    end
    view.fill = OCC_W'(shadow_count);
    if (shadow_count == 0) begin
      view.front_word = EMPTY_WORD;
      view.back_word  = EMPTY_WORD;
    end else begin
      view.front_word = shadow_ring[SH_W'(shadow_front)];
      view.back_word  = shadow_ring[SH_W'((shadow_front + shadow_count - 1) % DEPTH)];
    end
    return view;
  endfunction

  // Every mismatch is printed on one line and counted.
  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    error_count++;
    $display("MISMATCH %s: got %h, expected %h (cycle %0d)", what, got, want, cycle_count);
  endtask

  task automatic add_row(input dq_pkg::mode_t op, input logic signed [DATA_W-1:0] word,
                         input int unsigned reps, input bit typed,
                         input logic signed [DATA_W-1:0] want_front,
                         input logic signed [DATA_W-1:0] want_back,
                         input int unsigned want_fill, input dq_pkg::status_t want_stat);
    script_row_t row;
    row.op              = op;
    row.word            = word;
    row.reps            = reps;
    row.typed           = typed;
    row.want.front_word = want_front;
    row.want.back_word  = want_back;
    row.want.fill       = OCC_W'(want_fill);
    row.want.stat       = want_stat;
    script.insert(script.size(), row);
  endtask

  // This task sends one request. It may first idle the sender for a random gap. The
  // request is held until in_ready is seen high at a rising edge. The expectation is
  // queued once the request has been accepted, so the shadow queue advances in the
  // same order as the block.
  task automatic send_request(input dq_pkg::mode_t op, input logic signed [DATA_W-1:0] word,
                              input bit typed, input deque_view_t want);
    deque_view_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= op;
    in_push_value <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_deque_op(op, word);
    pending_views.insert(pending_views.size(), typed ? want : predicted);
  endtask

  // This block checks results and drives out_ready. The values it reads are the ones
  // from before the edge, so a result counts as accepted exactly when the block sees it
  // taken. The stall decision for the next cycle is made at the same edge.
  always @(posedge clk) begin : result_check
    deque_view_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_views.size() == 0) begin
        report_mismatch("result with no request pending", out_front_value, '0);
      end else begin
        want = pending_views[0];
        pending_views.delete(0);
        if (out_front_value !== want.front_word)
          report_mismatch("front_value", out_front_value, want.front_word);
        if (out_back_value !== want.back_word)
          report_mismatch("back_value", out_back_value, want.back_word);
        if (out_occupancy !== want.fill)
          report_mismatch("occupancy", DATA_W'(out_occupancy), DATA_W'(want.fill));
        if (out_status !== want.stat)
          report_mismatch("status", DATA_W'(out_status), DATA_W'(want.stat));
      end
    end
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // If the run hangs, this watchdog ends it.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int                       phase;
    int                       lean;
    int                       burst_left;
    int                       roll;
    bit                       is_push;
    dq_pkg::mode_t            op;
    logic signed [DATA_W-1:0] word;
    script_row_t              row;

    // Directed script. It starts on the empty queue after reset. It pops on empty at
    // both ends, pushes the extreme words, and moves the front index back across zero
    // and then forward again. It empties the queue with a status of ok and pushes the
    // all-ones word, which looks like the empty marker. Then it fills the queue to
    // the brim and pushes at both ends while it is full.
    add_row(dq_pkg::MODE_POP_BACK,   '0,         1, 1'b1, EMPTY_WORD, EMPTY_WORD, 0,
            dq_pkg::ST_EMPTY);
    add_row(dq_pkg::MODE_POP_FRONT,  '0,         1, 1'b1, EMPTY_WORD, EMPTY_WORD, 0,
            dq_pkg::ST_EMPTY);
    add_row(dq_pkg::MODE_PUSH_BACK,  WORD_MAX,   1, 1'b1, WORD_MAX,   WORD_MAX,   1,
            dq_pkg::ST_OK);
    add_row(dq_pkg::MODE_PUSH_FRONT, WORD_MIN,   1, 1'b1, WORD_MIN,   WORD_MAX,   2,
            dq_pkg::ST_OK);
    add_row(dq_pkg::MODE_POP_FRONT,  '0,         1, 1'b1, WORD_MAX,   WORD_MAX,   1,
            dq_pkg::ST_OK);
    add_row(dq_pkg::MODE_POP_BACK,   '0,         1, 1'b1, EMPTY_WORD, EMPTY_WORD, 0,
            dq_pkg::ST_OK);
    add_row(dq_pkg::MODE_PUSH_BACK,  EMPTY_WORD, 1, 1'b1, EMPTY_WORD, EMPTY_WORD, 1,
            dq_pkg::ST_OK);
    add_row(dq_pkg::MODE_PUSH_BACK,  32'sh1000_0000, DEPTH - 1, 1'b0, '0, '0, 0,
            dq_pkg::ST_OK);
    add_row(dq_pkg::MODE_PUSH_FRONT, 32'sh5555_5555, 1, 1'b1, EMPTY_WORD, 32'sh1000_000E,
            DEPTH, dq_pkg::ST_FULL);
    add_row(dq_pkg::MODE_PUSH_BACK,  32'shAAAA_AAAA, 1, 1'b1, EMPTY_WORD, 32'sh1000_000E,
            DEPTH, dq_pkg::ST_FULL);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      row = script[i];
      for (int k = 0; k < row.reps; k++) begin
        send_request(row.op, row.word + k, row.typed, row.want);
      end
    end

    // The random part comes in four idling phases. Requests come in bursts that lean
    // toward pushes, toward pops, or toward neither. This makes the fill level sweep
    // between empty and full over and over, so both overflow cases and pointer wraps
    // at both ends happen often. Pushed words favor the extremes, zero and all ones.
    burst_left = 0;
    lean       = 0;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 65;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 65;
        end
        default: begin
          sender_idle_pct    = 8;
          receiver_stall_pct = 8;
        end
      endcase
      repeat (PHASE_ITEMS) begin
        if (burst_left == 0) begin
          lean       = $urandom_range(2);
          burst_left = $urandom_range(8, 48);
        end
        burst_left--;
        roll = $urandom_range(99);
        case (lean)
          0:       is_push = (roll < 85);
          1:       is_push = (roll < 15);
          default: is_push = (roll < 50);
        endcase
        if (is_push) begin
          if ($urandom_range(1) != 0) op = dq_pkg::MODE_PUSH_FRONT;
          else                        op = dq_pkg::MODE_PUSH_BACK;
        end else begin
          if ($urandom_range(1) != 0) op = dq_pkg::MODE_POP_FRONT;
          else                        op = dq_pkg::MODE_POP_BACK;
        end
        case ($urandom_range(7))
          0:       word = WORD_MAX;
          1:       word = WORD_MIN;
          2:       word = EMPTY_WORD;
          3:       word = '0;
          default: word = $urandom;
        endcase
        send_request(op, word, 1'b0, '0);
      end
    end

    // All requests are in. Let the results drain with no stalls, then wait out the
    // drain time for anything unexpected.
    in_valid           <= 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
